// ===== rtl/http_response_body_extractor_top_assert.svh =====
// assertion macros for the body extractor
// no dependencies
`ifndef HTTP_RESPONSE_BODY_EXTRACTOR_TOP_ASSERT_SVH
`define HTTP_RESPONSE_BODY_EXTRACTOR_TOP_ASSERT_SVH
// implication checked every clock outside reset
`define HRBE_ASSERT_IMP(label, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define HRBE_ASSERT_NXT(label, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// ===== rtl/hrbe_pkg.sv =====
// shared types and constants for the body extractor
// no dependencies
`timescale 1ns / 1ps
package hrbe_pkg;
    localparam int LENGTH_BITS = 32;
    localparam logic [3:0] PH_IDLE = 4'd0;
    localparam logic [3:0] PH_HEADER = 4'd1;
    localparam logic [3:0] PH_BODY_COUNT = 4'd2;
    localparam logic [3:0] PH_BODY_CLOSE = 4'd3;
    localparam logic [3:0] PH_SIZE = 4'd4;
    localparam logic [3:0] PH_SIZE_SKIP = 4'd5;
    localparam logic [3:0] PH_DATA = 4'd6;
    localparam logic [3:0] PH_GAP1 = 4'd7;
    localparam logic [3:0] PH_GAP2 = 4'd8;
    localparam logic [3:0] PH_TRAILER = 4'd9;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = 2;
    typedef struct packed {
        logic [7:0] body_byte;
        logic       has_byte;
        logic       last;
        logic       status;
    } result_t;
    function automatic logic [7:0] enc_char(input logic [4:0] i);
        logic [7:0] c;
        begin
            case (i)
                5'd0: c = "T"; 5'd1: c = "r"; 5'd2: c = "a"; 5'd3: c = "n";
                5'd4: c = "s"; 5'd5: c = "f"; 5'd6: c = "e"; 5'd7: c = "r";
                5'd8: c = "-"; 5'd9: c = "E"; 5'd10: c = "n"; 5'd11: c = "c";
                5'd12: c = "o"; 5'd13: c = "d"; 5'd14: c = "i"; 5'd15: c = "n";
                5'd16: c = "g"; 5'd17: c = ":"; 5'd18: c = " "; 5'd19: c = "c";
                5'd20: c = "h"; 5'd21: c = "u"; 5'd22: c = "n"; 5'd23: c = "k";
                5'd24: c = "e"; 5'd25: c = "d";
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction
    function automatic logic [7:0] len_char(input logic [3:0] i);
        logic [7:0] c;
        begin
            case (i)
                4'd0: c = "C"; 4'd1: c = "o"; 4'd2: c = "n"; 4'd3: c = "t";
                4'd4: c = "e"; 4'd5: c = "n"; 4'd6: c = "t"; 4'd7: c = "-";
                4'd8: c = "L"; 4'd9: c = "e"; 4'd10: c = "n"; 4'd11: c = "g";
                4'd12: c = "t"; 4'd13: c = "h"; 4'd14: c = ":";
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction
endpackage

// ===== rtl/hrbe_front.sv =====
// front part: accepts bytes and close events, parses header and chunk framing
// depends on hrbe_pkg
`timescale 1ns / 1ps
module hrbe_front
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [7:0]               data_byte,
    input  logic                     closed,
    output logic                     res_valid,
    output hrbe_pkg::result_t        res,
    input  logic                     q_ready
);
    import hrbe_pkg::*;
    localparam logic [LENGTH_BITS-1:0] LMAX = {LENGTH_BITS{1'b1}};
    localparam logic [LENGTH_BITS-1:0] DEC_LIM = LMAX / 10;
    localparam logic [3:0] DEC_REM = 4'(LMAX % 10);

    logic [3:0]             phase_reg, phase_next;
    logic [1:0]             blank_reg, blank_next;
    logic [4:0]             enc_reg, enc_next;
    logic [3:0]             lkey_reg, lkey_next;
    logic                   chunked_reg, chunked_next;
    logic [1:0]             lfp_reg, lfp_next;
    logic [LENGTH_BITS-1:0] decl_reg, decl_next;
    logic [LENGTH_BITS-1:0] rem_reg, rem_next;

    logic       fire;
    logic [3:0] hexv;
    logic       is_hex;
    logic       blank_done;
    logic [1:0] bl_cur;
    logic [1:0] lfp_t;
    logic [7:0] bk;

    assign in_ready = q_ready;
    assign fire = in_valid && in_ready;

    always_comb
    begin
        is_hex = 1'b1;
        hexv = 4'd0;
        if (data_byte inside {["0":"9"]})
            hexv = 4'(data_byte - 8'h30);
        else if (data_byte inside {["a":"f"]})
            hexv = 4'(data_byte - 8'h57);
        else if (data_byte inside {["A":"F"]})
            hexv = 4'(data_byte - 8'h37);
        else
            is_hex = 1'b0;
    end

    always_comb
    begin
        phase_next = phase_reg;
        blank_next = blank_reg;
        enc_next = enc_reg;
        lkey_next = lkey_reg;
        chunked_next = chunked_reg;
        lfp_next = lfp_reg;
        decl_next = decl_reg;
        rem_next = rem_reg;
        res_valid = 1'b0;
        res = '0;
        blank_done = 1'b0;
        bl_cur = blank_reg;
        lfp_t = lfp_reg;
        bk = (bl_cur[0]) ? 8'd10 : 8'd13;
        if (fire && closed)
        begin
            case (phase_reg)
                PH_HEADER, PH_BODY_COUNT, PH_SIZE, PH_SIZE_SKIP, PH_DATA, PH_GAP1, PH_GAP2:
                begin
                    res_valid = 1'b1;
                    res.last = 1'b1;
                    res.status = 1'b1;
                end
                PH_BODY_CLOSE:
                begin
                    res_valid = 1'b1;
                    res.last = 1'b1;
                end
                default: ;
            endcase
            phase_next = PH_IDLE;
            blank_next = '0; enc_next = '0; lkey_next = '0; chunked_next = 1'b0;
            lfp_next = '0; decl_next = '0; rem_next = '0;
        end
        else if (fire)
        begin
            case (phase_reg)
                PH_IDLE, PH_HEADER:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        bl_cur = 2'd0; lfp_t = 2'd0; decl_next = '0;
                        enc_next = '0; lkey_next = '0; chunked_next = 1'b0;
                        rem_next = '0;
                    end
                    else
                    begin
                        enc_next = enc_reg; lkey_next = lkey_reg;
                        chunked_next = chunked_reg;
                    end
                    if (lfp_t == 2'd1 || lfp_t == 2'd2)
                    begin
                        if (data_byte inside {["0":"9"]})
                        begin
                            if (decl_next > DEC_LIM ||
                                (decl_next == DEC_LIM && hexv > DEC_REM))
                                decl_next = LMAX;
                            else
                                decl_next = LENGTH_BITS'(decl_next * 10) + LENGTH_BITS'(hexv);
                            lfp_t = 2'd2;
                        end
                        else if (!(data_byte == " " && lfp_t == 2'd1))
                            lfp_t = 2'd3;
                    end
                    if (lfp_t == 2'd0)
                    begin
                        if (data_byte == len_char(lkey_next))
                        begin
                            if (lkey_next == 4'd14)
                            begin
                                lkey_next = 4'd0;
                                lfp_t = 2'd1;
                            end
                            else
                                lkey_next = lkey_next + 4'd1;
                        end
                        else
                            lkey_next = (data_byte == "C") ? 4'd1 : 4'd0;
                    end
                    lfp_next = lfp_t;
                    if (!chunked_next)
                    begin
                        if (data_byte == enc_char(enc_next))
                        begin
                            if (enc_next == 5'd25)
                            begin
                                enc_next = 5'd0;
                                chunked_next = 1'b1;
                            end
                            else
                                enc_next = enc_next + 5'd1;
                        end
                        else
                            enc_next = (data_byte == "T") ? 5'd1 : 5'd0;
                    end
                    bk = (bl_cur[0]) ? 8'd10 : 8'd13;
                    if (data_byte == bk)
                    begin
                        blank_next = bl_cur + 2'd1;
                        blank_done = (bl_cur == 2'd3);
                    end
                    else
                        blank_next = (data_byte == 8'd13) ? 2'd1 : 2'd0;
                    phase_next = PH_HEADER;
                    if (blank_done)
                    begin
                        if (chunked_next)
                        begin
                            phase_next = PH_SIZE;
                            rem_next = '0;
                        end
                        else if (decl_next != '0)
                        begin
                            phase_next = PH_BODY_COUNT;
                            rem_next = decl_next;
                        end
                        else
                            phase_next = PH_BODY_CLOSE;
                    end
                end
                PH_BODY_COUNT:
                begin
                    res_valid = 1'b1;
                    res.body_byte = data_byte;
                    res.has_byte = 1'b1;
                    rem_next = rem_reg - 1'b1;
                    if (rem_reg == LENGTH_BITS'(1))
                    begin
                        res.last = 1'b1;
                        phase_next = PH_IDLE;
                        blank_next = '0; enc_next = '0; lkey_next = '0; chunked_next = 1'b0;
                        lfp_next = '0; decl_next = '0; rem_next = '0;
                    end
                end
                PH_BODY_CLOSE:
                begin
                    res_valid = 1'b1;
                    res.body_byte = data_byte;
                    res.has_byte = 1'b1;
                end
                PH_SIZE, PH_SIZE_SKIP:
                begin
                    if (data_byte == 8'd10)
                    begin
                        if (rem_reg == '0)
                        begin
                            res_valid = 1'b1;
                            res.last = 1'b1;
                            phase_next = PH_TRAILER;
                            blank_next = 2'd2;
                        end
                        else
                            phase_next = PH_DATA;
                    end
                    else if (phase_reg == PH_SIZE && is_hex)
                    begin
                        if (rem_reg[LENGTH_BITS-1 -: 4] != 4'd0)
                            rem_next = LMAX;
                        else
                            rem_next = {rem_reg[LENGTH_BITS-5:0], hexv};
                    end
                    else
                        phase_next = PH_SIZE_SKIP;
                end
                PH_DATA:
                begin
                    res_valid = 1'b1;
                    res.body_byte = data_byte;
                    res.has_byte = 1'b1;
                    rem_next = rem_reg - 1'b1;
                    if (rem_reg == LENGTH_BITS'(1))
                        phase_next = PH_GAP1;
                end
                PH_GAP1: phase_next = PH_GAP2;
                PH_GAP2:
                begin
                    phase_next = PH_SIZE;
                    rem_next = '0;
                end
                PH_TRAILER:
                begin
                    if (data_byte == bk)
                    begin
                        blank_next = bl_cur + 2'd1;
                        if (bl_cur == 2'd3)
                        begin
                            phase_next = PH_IDLE;
                            blank_next = '0; enc_next = '0; lkey_next = '0; chunked_next = 1'b0;
                            lfp_next = '0; decl_next = '0; rem_next = '0;
                        end
                    end
                    else
                        blank_next = (data_byte == 8'd13) ? 2'd1 : 2'd0;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    blank_next = '0; enc_next = '0; lkey_next = '0; chunked_next = 1'b0;
                    lfp_next = '0; decl_next = '0; rem_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            blank_reg <= '0;
            enc_reg <= '0;
            lkey_reg <= '0;
            chunked_reg <= 1'b0;
            lfp_reg <= '0;
            decl_reg <= '0;
            rem_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            blank_reg <= blank_next;
            enc_reg <= enc_next;
            lkey_reg <= lkey_next;
            chunked_reg <= chunked_next;
            lfp_reg <= lfp_next;
            decl_reg <= decl_next;
            rem_reg <= rem_next;
        end
    end

`include "http_response_body_extractor_top_assert.svh"
    `HRBE_ASSERT_IMP(a_no_res_unless_fire, res_valid, fire, "result without request")
    `HRBE_ASSERT_NXT(a_close_idles, fire && closed, phase_reg == PH_IDLE, "close left phase busy")
    `HRBE_ASSERT_IMP(a_data_nonzero, phase_reg == PH_DATA || phase_reg == PH_BODY_COUNT,
        rem_reg != '0, "data phase with zero count")
endmodule

// ===== rtl/hrbe_queue.sv =====
// back part: short result queue feeding the master stream
// depends on hrbe_pkg
`timescale 1ns / 1ps
module hrbe_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_valid,
    input  hrbe_pkg::result_t  wr_data,
    output logic               wr_ready,
    output logic               rd_valid,
    output hrbe_pkg::result_t  rd_data,
    input  logic               rd_ready
);
    import hrbe_pkg::*;
    result_t           mem [QUEUE_DEPTH];
    logic [QUEUE_AW:0] cnt_reg, cnt_next;
    logic [QUEUE_AW-1:0] wp_reg, rp_reg;
    logic wr, rd;

    assign wr_ready = (cnt_reg < (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign rd_valid = cnt_reg != '0;
    assign rd_data = mem[rp_reg];
    assign wr = wr_valid;
    assign rd = rd_valid && rd_ready;
    assign cnt_next = cnt_reg + (QUEUE_AW+1)'(wr) - (QUEUE_AW+1)'(rd);

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg <= '0;
            rp_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (wr)
                wp_reg <= wp_reg + 1'b1;
            if (rd)
                rp_reg <= rp_reg + 1'b1;
        end
    end

`include "http_response_body_extractor_top_assert.svh"
    `HRBE_ASSERT_IMP(a_no_overflow, wr && !rd, cnt_reg < (QUEUE_AW+1)'(QUEUE_DEPTH),
        "queue overflow")
    `HRBE_ASSERT_NXT(a_cnt_track, wr && !rd, cnt_reg == $past(cnt_reg) + 1'b1,
        "queue count slip")
    `HRBE_ASSERT_IMP(a_no_underflow, rd, cnt_reg != '0, "queue underflow")
endmodule

// ===== rtl/http_response_body_extractor_top.sv =====
// HTTP response body extractor, top level
// depends on hrbe_pkg, hrbe_front, hrbe_queue
`timescale 1ns / 1ps
// Takes one response byte (or a close event, tuser=1) per request and gives
// the decoded body, one result per byte at most; one request per cycle is
// sustained while the queue is not full, as the parser updates all matchers and
// counters for a byte in one step and a four-entry queue decouples output.
module http_response_body_extractor_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // closed
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // body_byte
    output logic [1:0]  m_axis_tuser,   // has_byte, status
    output logic        m_axis_tlast
);
    import hrbe_pkg::*;
    logic    rv, qr;
    result_t r, q;

    hrbe_front u_front
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .data_byte(s_axis_tdata), .closed(s_axis_tuser),
        .res_valid(rv), .res(r), .q_ready(qr)
    );

    hrbe_queue u_queue
    (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(rv), .wr_data(r), .wr_ready(qr),
        .rd_valid(m_axis_tvalid), .rd_data(q), .rd_ready(m_axis_tready)
    );

    assign m_axis_tdata = q.body_byte;
    assign m_axis_tuser = {q.status, q.has_byte};
    assign m_axis_tlast = q.last;
endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench for the http response body extractor
// depends on hrbe_pkg and http_response_body_extractor_top
`timescale 1ns / 1ps
module tb_top;
    import hrbe_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       s_axis_tuser;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic       m_axis_tlast;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       closed;
    } req_t;

    typedef struct {
        req_t    req;
        logic    known;
        result_t res;
        logic    has_res;
    } stim_row_t;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    http_response_body_extractor_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // predictor state
    logic [3:0]             ph;
    int unsigned            blank_cnt;
    int unsigned            enc_cnt;
    int unsigned            len_cnt;
    logic                   chunked;
    int unsigned            len_state;
    logic [LENGTH_BITS-1:0] len_val;
    logic [LENGTH_BITS-1:0] remain;

    result_t    body_q[$];
    int         errors;
    int         send_idle;
    int         recv_stall;
    req_t       pending[$];
    stim_row_t  rows[$];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = 1'b1;
            #1 clk = 1'b0;
        end
    end

    function automatic logic [7:0] enc_at(int unsigned i);
        string s;
        s = "Transfer-Encoding: chunked";
        return s[i];
    endfunction

    function automatic logic [7:0] len_at(int unsigned i);
        string s;
        s = "Content-Length:";
        return s[i];
    endfunction

    task automatic clear_hdr();
        blank_cnt = 0;
        enc_cnt = 0;
        len_cnt = 0;
        chunked = 1'b0;
        len_state = 0;
        len_val = '0;
        remain = '0;
    endtask

    function automatic logic blank_hit(logic [7:0] b);
        logic [7:0] k;
        k = (blank_cnt[0] == 1'b0) ? 8'd13 : 8'd10;
        if (b == k)
        begin
            blank_cnt++;
            if (blank_cnt >= 4)
            begin
                blank_cnt = 0;
                return 1'b1;
            end
        end
        else
            blank_cnt = (b == 8'd13) ? 1 : 0;
        return 1'b0;
    endfunction

    function automatic int hex_of(logic [7:0] b);
        if (b >= "0" && b <= "9") return b - "0";
        if (b >= "a" && b <= "f") return b - "a" + 10;
        if (b >= "A" && b <= "F") return b - "A" + 10;
        return -1;
    endfunction

    task automatic scan_header(logic [7:0] b);
        logic [LENGTH_BITS-1:0] d;
        if (len_state == 1 || len_state == 2)
        begin
            if (b >= "0" && b <= "9")
            begin
                d = b - "0";
                if (len_val > (LEN_MAX - d) / 10) len_val = LEN_MAX;
                else len_val = len_val * 10 + d;
                len_state = 2;
            end
            else if (!(b == " " && len_state == 1))
                len_state = 3;
        end
        if (len_state == 0)
        begin
            if (b == len_at(len_cnt))
            begin
                len_cnt++;
                if (len_cnt >= 15)
                begin
                    len_cnt = 0;
                    len_state = 1;
                end
            end
            else
                len_cnt = (b == "C") ? 1 : 0;
        end
        if (!chunked)
        begin
            if (enc_cnt < 26 && b == enc_at(enc_cnt))
            begin
                enc_cnt++;
                if (enc_cnt >= 26)
                begin
                    enc_cnt = 0;
                    chunked = 1'b1;
                end
            end
            else
                enc_cnt = (b == "T") ? 1 : 0;
        end
        if (blank_hit(b))
        begin
            if (chunked)
            begin
                ph = PH_SIZE;
                remain = '0;
            end
            else if (len_val != 0)
            begin
                ph = PH_BODY_COUNT;
                remain = len_val;
            end
            else
                ph = PH_BODY_CLOSE;
        end
    endtask

    task automatic predict_body(req_t r, output logic hit, output result_t res);
        logic [7:0]             b;
        int                     h;
        logic [LENGTH_BITS-1:0] d;
        b = r.data_byte;
        hit = 1'b0;
        res = '0;
        if (r.closed)
        begin
            if (ph inside {PH_HEADER, PH_BODY_COUNT, PH_SIZE, PH_SIZE_SKIP, PH_DATA,
                           PH_GAP1, PH_GAP2})
            begin
                hit = 1'b1;
                res.last = 1'b1;
                res.status = 1'b1;
            end
            else if (ph == PH_BODY_CLOSE)
            begin
                hit = 1'b1;
                res.last = 1'b1;
            end
            clear_hdr();
            ph = PH_IDLE;
            return;
        end
        case (ph)
            PH_IDLE:
            begin
                clear_hdr();
                ph = PH_HEADER;
                scan_header(b);
            end
            PH_HEADER: scan_header(b);
            PH_BODY_COUNT:
            begin
                hit = 1'b1;
                res.body_byte = b;
                res.has_byte = 1'b1;
                remain--;
                if (remain == 0)
                begin
                    res.last = 1'b1;
                    clear_hdr();
                    ph = PH_IDLE;
                end
            end
            PH_BODY_CLOSE:
            begin
                hit = 1'b1;
                res.body_byte = b;
                res.has_byte = 1'b1;
            end
            PH_SIZE, PH_SIZE_SKIP:
            begin
                h = hex_of(b);
                if (b == 8'd10)
                begin
                    if (remain == 0)
                    begin
                        hit = 1'b1;
                        res.last = 1'b1;
                        ph = PH_TRAILER;
                        blank_cnt = 2;
                    end
                    else
                        ph = PH_DATA;
                end
                else if (ph == PH_SIZE && h >= 0)
                begin
                    d = h;
                    if (remain > ((LEN_MAX - d) >> 4)) remain = LEN_MAX;
                    else remain = (remain << 4) + d;
                end
                else
                    ph = PH_SIZE_SKIP;
            end
            PH_DATA:
            begin
                hit = 1'b1;
                res.body_byte = b;
                res.has_byte = 1'b1;
                remain--;
                if (remain == 0) ph = PH_GAP1;
            end
            PH_GAP1: ph = PH_GAP2;
            PH_GAP2:
            begin
                ph = PH_SIZE;
                remain = '0;
            end
            PH_TRAILER:
                if (blank_hit(b))
                begin
                    clear_hdr();
                    ph = PH_IDLE;
                end
            default:
            begin
                clear_hdr();
                ph = PH_IDLE;
            end
        endcase
    endtask

    task automatic push_str(string s);
        req_t r;
        for (int i = 0; i < s.len(); i++)
        begin
            r.data_byte = s[i];
            r.closed = 1'b0;
            pending.push_back(r);
        end
    endtask

    task automatic push_close();
        req_t r;
        r.data_byte = $urandom_range(255);
        r.closed = 1'b1;
        pending.push_back(r);
    endtask

    task automatic push_noise(int n);
        req_t r;
        for (int i = 0; i < n; i++)
        begin
            r.data_byte = $urandom_range(255);
            r.closed = ($urandom_range(40) == 0);
            pending.push_back(r);
        end
    endtask

    task automatic push_payload(int n);
        req_t r;
        for (int i = 0; i < n; i++)
        begin
            r.data_byte = $urandom_range(255);
            r.closed = 1'b0;
            pending.push_back(r);
        end
    endtask

    // one random response: mostly well formed, some truncated
    task automatic build_response();
        int kind;
        int n;
        kind = $urandom_range(5);
        push_str("HTTP/1.1 200 OK\r\n");
        if ($urandom_range(3) == 0) push_str("X-Conn: Content-Lengt\r\n");
        case (kind)
            0, 1:
            begin
                n = $urandom_range(1, 12);
                push_str($sformatf("Content-Length: %0d\r\n\r\n", n));
                push_payload(n);
            end
            2, 3:
            begin
                push_str("Transfer-Encoding: chunked\r\n");
                if (kind == 3) push_str("Content-Length: 3\r\n");
                push_str("\r\n");
                repeat ($urandom_range(0, 3))
                begin
                    n = $urandom_range(1, 10);
                    if ($urandom_range(1)) push_str($sformatf("%0x;ext=1\r\n", n));
                    else push_str($sformatf("%0X\r\n", n));
                    push_payload(n);
                    push_str("\r\n");
                end
                if ($urandom_range(1)) push_str("0\r\nTrailer: x\r\n\r\n");
                else push_str("0\r\n\r\n");
            end
            4:
            begin
                push_str("\r\n");
                push_payload($urandom_range(0, 8));
                push_close();
            end
            default:
            begin
                push_str("Content-Length: 20\r\n\r\n");
                push_payload($urandom_range(0, 10));
                push_close();
            end
        endcase
    endtask

    // directed table
    task automatic add_row(logic [7:0] b, logic c, logic known, result_t res, logic has);
        stim_row_t r;
        r.req.data_byte = b;
        r.req.closed = c;
        r.known = known;
        r.res = res;
        r.has_res = has;
        rows.push_back(r);
    endtask

    task automatic send_req(req_t r);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= r.data_byte;
        s_axis_tuser <= r.closed;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic issue(req_t r, logic known, result_t kres, logic khas);
        logic    hit;
        result_t res;
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        predict_body(r, hit, res);
        if (known && (hit !== khas || (hit && res !== kres)))
        begin
            $display("%0t: table row mismatch expected %0d/%h actual %0d/%h",
                     $time, khas, kres, hit, res);
            errors++;
        end
        if (hit) body_q.push_back(res);
        send_req(r);
    endtask

    always @(posedge clk)
    begin
        result_t got;
        result_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.body_byte = m_axis_tdata;
            got.has_byte = m_axis_tuser[0];
            got.status = m_axis_tuser[1];
            got.last = m_axis_tlast;
            if (body_q.size() == 0)
            begin
                $display("%0t: unexpected result expected none actual %h", $time, got);
                errors++;
            end
            else
            begin
                exp_r = body_q.pop_front();
                if (got !== exp_r)
                begin
                    $display("%0t: result mismatch expected %h actual %h",
                             $time, exp_r, got);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall);

    initial
    begin
        #400000;
        $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        result_t z;
        result_t lc;
        result_t le;
        string   hdr;
        int      wait_cnt;
        errors = 0;
        send_idle = 0;
        recv_stall = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        clear_hdr();
        ph = PH_IDLE;
        z = '0;
        lc = '0;
        lc.last = 1'b1;
        le = lc;
        le.status = 1'b1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // close while idle, header closes, body delimited by close
        add_row(8'hff, 1'b1, 1'b1, z, 1'b0);
        add_row(8'h00, 1'b0, 1'b1, z, 1'b0);
        add_row(8'hff, 1'b1, 1'b1, le, 1'b0 | 1'b1);
        hdr = "\r\n\r\n";
        for (int i = 0; i < hdr.len(); i++) add_row(hdr[i], 1'b0, 1'b1, z, 1'b0);
        add_row(8'h00, 1'b0, 1'b0, z, 1'b0);
        add_row(8'hff, 1'b0, 1'b0, z, 1'b0);
        add_row(8'h00, 1'b1, 1'b1, lc, 1'b1);
        foreach (rows[i]) issue(rows[i].req, rows[i].known, rows[i].res, rows[i].has_res);

        // saturating length and chunk size, cut short by close; empty chunked body; bad length
        push_str("Content-Length:  99999999999999\r\n\r\nab");
        push_close();
        push_str("Transfer-Encoding: chunked\r\n\r\nFFFFFFFFFFFF\r\nxy");
        push_close();
        push_str("Transfer-Encoding: chunked\r\n\r\n0\r\n\r\n");
        push_str("Content-Length: x\r\n\r\nqq");
        push_close();
        while (pending.size() > 0) issue(pending.pop_front(), 1'b0, z, 1'b0);

        for (int phase_i = 0; phase_i < 4; phase_i++)
        begin
            case (phase_i)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 80; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 80; end
                default: begin send_idle = 30; recv_stall = 30; end
            endcase
            while (pending.size() < 360)
            begin
                if ($urandom_range(9) == 0) push_noise($urandom_range(1, 20));
                else build_response();
            end
            while (pending.size() > 0) issue(pending.pop_front(), 1'b0, z, 1'b0);
            if (phase_i == 1)
            begin
                s_axis_tvalid <= 1'b0;
                while (body_q.size() > 0) @(negedge clk);
            end
        end

        s_axis_tvalid <= 1'b0;
        wait_cnt = 0;
        while (body_q.size() > 0 && wait_cnt < 20000)
        begin
            @(negedge clk);
            wait_cnt++;
        end
        repeat (20) @(negedge clk);
        if (errors == 0 && body_q.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
